/* sv/alir_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alir_pkg: shared types for the array list
// Operation and status codes, transfer payloads and the decode result.
// ----------------------------------------------------------------------------
package alir_pkg;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_REM_HEAD = 3'd3,
    OP_REM_TAIL = 3'd4,
    OP_REM_POS  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [8:0]  position;
    logic [31:0] entry_value;
  } in_t;

  typedef struct packed {
    logic [31:0] removed_value;
    logic [1:0]  status;
    logic [8:0]  entry_count;
  } out_t;

  typedef struct packed {
    logic    ins;
    logic    rem;
    status_t status;
  } dec_t;

endpackage

/* sv/array_list_insert_remove.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_remove: bounded ordered list in a single-port-pair memory
// Inserts and removes at any index, shifting later entries one move a cycle.
// ----------------------------------------------------------------------------
// Raise start while busy is low to transfer one operation; exactly one result
// follows as a one-cycle out_valid strobe and cannot be held off. Rejected
// operations, unused codes and inserts at the tail skip the shift loop; their
// result follows in the next cycle. Any other insert at index k moves entries
// k and up one place up, then writes the new entry at k; a remove at index k
// reads that entry, then moves the later entries one place down. The shift
// loop moves one entry per cycle through the memory's one read and one write
// port. No clearing pass after reset: only entries below the count are read.
module array_list_insert_remove #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  alir_pkg::in_t  in_item,
  output logic           out_valid,
  output alir_pkg::out_t out_item
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_PUT  = 5'b00100,
    S_TAKE = 5'b01000,
    S_REM  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]   lo_r, lo_nxt;
  logic [ADDR_W-1:0]   hi_r, hi_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic [DATA_WIDTH-1:0] taken_r, taken_nxt;
  logic                out_valid_r, out_valid_nxt;
  alir_pkg::out_t      out_r, out_nxt;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_wa, mem_ra;
  logic [DATA_WIDTH-1:0] mem_wd;

  alir_pkg::dec_t      dec;
  logic [ADDR_W-1:0]   at;
  logic [CNT_W-1:0]    cnt_dec;
  logic                accept;

  alir_decode #(
    .DEPTH (DEPTH)
  ) u_decode (
    .item  (in_item),
    .count (count_r),
    .dec   (dec),
    .at    (at)
  );

  assign cnt_dec   = count_r - 1'b1;
  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    word_nxt      = word_r;
    taken_nxt     = taken_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_re        = 1'b0;
    mem_ra        = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (dec.ins) begin
            count_nxt = count_r + 1'b1;
            if (CNT_W'(at) == count_r) begin
              mem_we        = 1'b1;
              mem_wa        = at;
              mem_wd        = DATA_WIDTH'(in_item.entry_value);
              out_valid_nxt = 1'b1;
              out_nxt       = '{32'd0, alir_pkg::ST_OK, 9'(count_nxt)};
            end else begin
              mem_re    = 1'b1;
              mem_ra    = cnt_dec[ADDR_W-1:0];
              ptr_nxt   = cnt_dec[ADDR_W-1:0];
              lo_nxt    = at;
              word_nxt  = DATA_WIDTH'(in_item.entry_value);
              state_nxt = S_INS;
            end
          end else if (dec.rem) begin
            count_nxt = cnt_dec;
            mem_re    = 1'b1;
            mem_ra    = at;
            ptr_nxt   = at;
            hi_nxt    = cnt_dec[ADDR_W-1:0];
            state_nxt = S_TAKE;
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{32'd0, dec.status, 9'(count_r)};
          end
        end
      end
      S_INS: begin
        mem_we = 1'b1;
        mem_wa = ptr_r + 1'b1;
        mem_wd = rd_data_r;
        if (ptr_r == lo_r) begin
          state_nxt = S_PUT;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = ptr_r - 1'b1;
          ptr_nxt = ptr_r - 1'b1;
        end
      end
      S_PUT: begin
        mem_we        = 1'b1;
        mem_wa        = lo_r;
        mem_wd        = word_r;
        out_valid_nxt = 1'b1;
        out_nxt       = '{32'd0, alir_pkg::ST_OK, 9'(count_r)};
        state_nxt     = S_IDLE;
      end
      S_TAKE: begin
        taken_nxt = rd_data_r;
        if (ptr_r == hi_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{32'(rd_data_r), alir_pkg::ST_OK, 9'(count_r)};
          state_nxt     = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = ptr_r + 1'b1;
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = S_REM;
        end
      end
      S_REM: begin
        mem_we = 1'b1;
        mem_wa = ptr_r - 1'b1;
        mem_wd = rd_data_r;
        if (ptr_r == hi_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{32'(taken_r), alir_pkg::ST_OK, 9'(count_r)};
          state_nxt     = S_IDLE;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = ptr_r + 1'b1;
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    word_r  <= word_nxt;
    taken_r <= taken_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !dec.ins && !dec.rem) |=> (out_valid && !busy))
    else $error("rejected operation did not finish in one cycle");

  a_ins_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> (ptr_r >= lo_r))
    else $error("insert shift ran below target index");

endmodule

/* sv/alir_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alir_decode: operation decode and bounds check
// Resolves the target index of an operation and its status against the count.
// ----------------------------------------------------------------------------
module alir_decode #(
  parameter int DEPTH = 256
) (
  input  alir_pkg::in_t                  item,
  input  logic [$clog2(DEPTH+1)-1:0]     count,
  output alir_pkg::dec_t                 dec,
  output logic [$clog2(DEPTH)-1:0]       at
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PW     = (CNT_W > 9) ? CNT_W : 9;

  logic             full;
  logic             empty;
  logic [PW-1:0]    pos_w;
  logic [PW-1:0]    cnt_w;
  logic [CNT_W-1:0] cnt_dec;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pos_w   = PW'(item.position);
  assign cnt_w   = PW'(count);
  assign cnt_dec = count - 1'b1;

  always_comb begin
    dec.ins    = 1'b0;
    dec.rem    = 1'b0;
    dec.status = alir_pkg::ST_OK;
    at         = '0;
    case (alir_pkg::op_t'(item.operation))
      alir_pkg::OP_INS_HEAD: begin
        if (full) dec.status = alir_pkg::ST_FULL;
        else      dec.ins    = 1'b1;
      end
      alir_pkg::OP_INS_TAIL: begin
        at = count[ADDR_W-1:0];
        if (full) dec.status = alir_pkg::ST_FULL;
        else      dec.ins    = 1'b1;
      end
      alir_pkg::OP_INS_POS: begin
        at = pos_w[ADDR_W-1:0];
        if (full)               dec.status = alir_pkg::ST_FULL;
        else if (pos_w > cnt_w) dec.status = alir_pkg::ST_RANGE;
        else                    dec.ins    = 1'b1;
      end
      alir_pkg::OP_REM_HEAD: begin
        if (empty) dec.status = alir_pkg::ST_EMPTY;
        else       dec.rem    = 1'b1;
      end
      alir_pkg::OP_REM_TAIL: begin
        at = cnt_dec[ADDR_W-1:0];
        if (empty) dec.status = alir_pkg::ST_EMPTY;
        else       dec.rem    = 1'b1;
      end
      alir_pkg::OP_REM_POS: begin
        at = pos_w[ADDR_W-1:0];
        if (empty)               dec.status = alir_pkg::ST_EMPTY;
        else if (pos_w >= cnt_w) dec.status = alir_pkg::ST_RANGE;
        else                     dec.rem    = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule
